[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SWSS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("swss check failed");

// Consequent must hold in the cycle after the antecedent.
`define SWSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swss check failed");

`endif

[hw/rtl/swss_pkg.sv]
// Shared types and constants of the skid-steer wheel speed block.
package swss_pkg;

   localparam int CMD_W    = 16;
   localparam int SPEED_W  = 24;
   localparam int GAIN_W   = 24;
   localparam int MS_W     = 16;
   localparam int TIME_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Shared multiplier operands and product.
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 26;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // floor(2^27 / 5); quotient estimate is low by at most one.
   localparam logic [24:0] RECIP_DIV5 = 25'd26843545;
   localparam int          RECIP_SHIFT = 27;
   localparam int          QUOT_W = 21;

   localparam logic [CSR_IDX_W-1:0] CSR_FWD_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP   = 3'd3;

   localparam logic [GAIN_W-1:0] FWD_GAIN_RESET  = 24'd655360;
   localparam logic [GAIN_W-1:0] TURN_GAIN_RESET = 24'd131072;
   localparam logic [MS_W-1:0]   TIMEOUT_RESET   = 16'd100;
   localparam logic [MS_W-1:0]   MIN_GAP_RESET   = 16'd50;

   typedef struct packed {
      logic [GAIN_W-1:0] forward_gain_q16;
      logic [GAIN_W-1:0] turn_gain_q16;
      logic [MS_W-1:0]   command_timeout_ms;
      logic [MS_W-1:0]   status_min_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic signed [CMD_W-1:0]   translation;
      logic signed [CMD_W-1:0]   rotation;
      logic                      status_seen;
      logic signed [SPEED_W-1:0] left_measured;
      logic signed [SPEED_W-1:0] right_measured;
   } hold_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] left_main_speed;
      logic signed [SPEED_W-1:0] left_other_speed;
      logic signed [SPEED_W-1:0] right_main_speed;
      logic signed [SPEED_W-1:0] right_other_speed;
   } result_type;

   typedef struct packed {
      logic busy;
      logic load;
   } seq_status_type;

endpackage

[hw/rtl/swss_if.sv]
// Channel interfaces: update requests, speed results, register writes.
interface swss_req_if;
   logic                                valid;
   logic                                ready;
   logic                                new_command;
   logic signed [swss_pkg::CMD_W-1:0]   translation_mm_s;
   logic signed [swss_pkg::CMD_W-1:0]   rotation_mrad_s;
   logic                                new_status;
   logic [swss_pkg::TIME_W-1:0]         status_time_ms;
   logic signed [swss_pkg::SPEED_W-1:0] left_main_measured;
   logic signed [swss_pkg::SPEED_W-1:0] right_main_measured;
   logic [swss_pkg::TIME_W-1:0]         now_ms;

   modport source (output valid, new_command, translation_mm_s, rotation_mrad_s,
                   new_status, status_time_ms, left_main_measured,
                   right_main_measured, now_ms, input ready);
   modport sink (input valid, new_command, translation_mm_s, rotation_mrad_s,
                 new_status, status_time_ms, left_main_measured,
                 right_main_measured, now_ms, output ready);
endinterface

interface swss_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [swss_pkg::SPEED_W-1:0] left_main_speed;
   logic signed [swss_pkg::SPEED_W-1:0] left_other_speed;
   logic signed [swss_pkg::SPEED_W-1:0] right_main_speed;
   logic signed [swss_pkg::SPEED_W-1:0] right_other_speed;

   modport source (output valid, left_main_speed, left_other_speed,
                   right_main_speed, right_other_speed, input ready);
   modport sink (input valid, left_main_speed, left_other_speed,
                 right_main_speed, right_other_speed, output ready);
endinterface

interface swss_csr_if;
   logic                                valid;
   logic                                ready;
   logic [swss_pkg::CSR_IDX_W-1:0]      index;
   logic [swss_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/swss_csr.sv]
// Configuration registers: gains, command timeout and status gap.
module swss_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [swss_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [swss_pkg::CSR_DATA_W-1:0] wr_data,
   output swss_pkg::cfg_type               cfg
);

   swss_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            swss_pkg::CSR_FWD_GAIN:  cfg_in.forward_gain_q16   = wr_data;
            swss_pkg::CSR_TURN_GAIN: cfg_in.turn_gain_q16      = wr_data;
            swss_pkg::CSR_TIMEOUT:   cfg_in.command_timeout_ms = wr_data[15:0];
            swss_pkg::CSR_MIN_GAP:   cfg_in.status_min_gap_ms  = wr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.forward_gain_q16   <= swss_pkg::FWD_GAIN_RESET;
         cfg_ff.turn_gain_q16      <= swss_pkg::TURN_GAIN_RESET;
         cfg_ff.command_timeout_ms <= swss_pkg::TIMEOUT_RESET;
         cfg_ff.status_min_gap_ms  <= swss_pkg::MIN_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/swss_hold.sv]
// Held motion command with timeout, and gated wheel status sample.
module swss_hold (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                new_command,
   input  logic signed [swss_pkg::CMD_W-1:0]   translation_mm_s,
   input  logic signed [swss_pkg::CMD_W-1:0]   rotation_mrad_s,
   input  logic                                new_status,
   input  logic [swss_pkg::TIME_W-1:0]         status_time_ms,
   input  logic signed [swss_pkg::SPEED_W-1:0] left_main_measured,
   input  logic signed [swss_pkg::SPEED_W-1:0] right_main_measured,
   input  logic [swss_pkg::TIME_W-1:0]         now_ms,
   input  swss_pkg::cfg_type                   cfg,
   output swss_pkg::hold_type                  hold
);

   swss_pkg::hold_type          hold_ff, hold_in;
   logic                        cmd_seen_ff, cmd_seen_in;
   logic [swss_pkg::TIME_W-1:0] cmd_time_ff, cmd_time_in;
   logic [swss_pkg::TIME_W-1:0] stat_time_ff, stat_time_in;
   logic [swss_pkg::TIME_W-1:0] cmd_age, stat_age;
   logic                        expired, newer;

   assign cmd_age  = now_ms - cmd_time_ff;
   assign stat_age = status_time_ms - stat_time_ff;
   assign expired  = cmd_seen_ff &&
                     (cmd_age >= {16'd0, cfg.command_timeout_ms});
   // age is signed mod 2^32: negative means older
   assign newer    = !stat_age[swss_pkg::TIME_W-1] &&
                     (stat_age > {16'd0, cfg.status_min_gap_ms});

   always_comb begin
      hold_in      = hold_ff;
      cmd_seen_in  = cmd_seen_ff;
      cmd_time_in  = cmd_time_ff;
      stat_time_in = stat_time_ff;
      if (accept) begin
         if (new_command) begin
            hold_in.translation = translation_mm_s;
            hold_in.rotation    = rotation_mrad_s;
            cmd_seen_in         = 1'b1;
            cmd_time_in         = now_ms;
         end else if (expired) begin
            hold_in.translation = '0;
            hold_in.rotation    = '0;
            cmd_seen_in         = 1'b0;
         end
         if (new_status && (!hold_ff.status_seen || newer)) begin
            hold_in.status_seen    = 1'b1;
            hold_in.left_measured  = left_main_measured;
            hold_in.right_measured = right_main_measured;
            stat_time_in           = status_time_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= '0;
         cmd_seen_ff  <= 1'b0;
         cmd_time_ff  <= '0;
         stat_time_ff <= '0;
      end else begin
         hold_ff      <= hold_in;
         cmd_seen_ff  <= cmd_seen_in;
         cmd_time_ff  <= cmd_time_in;
         stat_time_ff <= stat_time_in;
      end
   end

   assign hold = hold_ff;

endmodule

[hw/rtl/swss_mult.sv]
// Shared signed multiplier with registered product.
module swss_mult (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [swss_pkg::MUL_A_W-1:0] op_a,
   input  logic signed [swss_pkg::MUL_B_W-1:0] op_b,
   output logic signed [swss_pkg::MUL_P_W-1:0] product
);

   logic signed [swss_pkg::MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= op_a * op_b;
      end
   end

   assign product = prod_ff;

endmodule

[hw/rtl/swss_seq.sv]
// Sequencer and datapath: wheel speeds from the held command over the shared multiplier.
module swss_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  swss_pkg::hold_type                  hold,
   input  swss_pkg::cfg_type                   cfg,
   input  logic                                out_ready,
   output logic                                out_valid,
   output swss_pkg::result_type                result,
   output swss_pkg::seq_status_type            status
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL_F = 7'b0000010,
      ST_MUL_D = 7'b0000100,
      ST_SUM_L = 7'b0001000,
      ST_SUM_R = 7'b0010000,
      ST_DIV_R = 7'b0100000,
      ST_FIN_R = 7'b1000000
   } state_type;

   localparam int SUM_W = 42;

   function automatic logic signed [23:0] round_sat(input logic signed [SUM_W-1:0] q);
      logic              neg;
      logic [SUM_W-1:0]  mag;
      logic [25:0]       r;
      logic [23:0]       v;
      neg = q[SUM_W-1];
      mag = neg ? SUM_W'(-q) : SUM_W'(q);
      r   = 26'((mag + SUM_W'(32'h8000)) >> 16);
      if (neg) begin
         v = (r >= 26'h800000) ? {1'b1, 23'd0} : 24'(26'd0 - r);
      end else begin
         v = (r > 26'h7fffff) ? 24'h7fffff : r[23:0];
      end
      return $signed(v);
   endfunction

   // q0 is floor(|w|/5) or one less; the remainder fixes it and rounds.
   function automatic logic signed [23:0] other_speed(input logic signed [23:0] w,
                                                      input logic signed [23:0] meas,
                                                      input logic [swss_pkg::QUOT_W-1:0] q0);
      logic [23:0] aw, m, res;
      logic [25:0] m5;
      logic [24:0] rem0;
      logic [3:0]  remn;
      logic [21:0] r;
      aw   = w[23] ? 24'(-w) : 24'(w);
      m    = meas[23] ? 24'(-meas) : 24'(meas);
      m5   = {2'b00, m} + {m, 2'b00};
      rem0 = {1'b0, aw} - ({4'b0000, q0} + {2'b00, q0, 2'b00});
      remn = rem0[3:0];
      r    = {1'b0, q0} + 22'(remn >= 4'd3) + 22'(remn >= 4'd8);
      if (m >= aw) begin
         res = w;
      end else if (m5 < {2'b00, aw}) begin
         res = w[23] ? 24'(24'd0 - {2'b00, r}) : {2'b00, r};
      end else begin
         res = w[23] ? 24'(24'd0 - m) : m;
      end
      return $signed(res);
   endfunction

   state_type                            state_ff, state_in;
   logic signed [40:0]                   fwd_ff, fwd_in;
   logic signed [40:0]                   dif_ff, dif_in;
   logic signed [23:0]                   wl_ff, wl_in, wr_ff, wr_in;
   logic signed [23:0]                   ol_ff, ol_in;
   swss_pkg::result_type                 out_ff, out_in;
   logic                                 out_valid_ff, out_valid_in;
   logic                                 mul_en, load;
   logic signed [swss_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [swss_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [swss_pkg::MUL_P_W-1:0]  prod;
   logic [swss_pkg::QUOT_W-1:0]          quot;
   logic [23:0]                          abs_l, abs_r;

   swss_mult u_mult (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   assign quot  = prod[swss_pkg::RECIP_SHIFT + swss_pkg::QUOT_W - 1 : swss_pkg::RECIP_SHIFT];
   assign abs_l = wl_ff[23] ? 24'(-wl_ff) : 24'(wl_ff);
   assign abs_r = wr_ff[23] ? 24'(-wr_ff) : 24'(wr_ff);
   assign load  = (state_ff == ST_FIN_R) && (!out_valid_ff || out_ready);

   always_comb begin
      mul_a = {1'b0, abs_l};
      mul_b = {1'b0, swss_pkg::RECIP_DIV5};
      unique case (state_ff)
         ST_MUL_F: begin
            mul_a = swss_pkg::MUL_A_W'(hold.translation);
            mul_b = {2'b00, cfg.forward_gain_q16};
         end
         ST_MUL_D: begin
            mul_a = swss_pkg::MUL_A_W'(hold.rotation);
            mul_b = {2'b00, cfg.turn_gain_q16};
         end
         ST_DIV_R: mul_a = {1'b0, abs_r};
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      fwd_in       = fwd_ff;
      dif_in       = dif_ff;
      wl_in        = wl_ff;
      wr_in        = wr_ff;
      ol_in        = ol_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !out_ready;
      mul_en       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_MUL_F;
         end
         ST_MUL_F: begin
            mul_en   = 1'b1;
            // no result until a status sample has been kept
            state_in = hold.status_seen ? ST_MUL_D : ST_IDLE;
         end
         ST_MUL_D: begin
            mul_en   = 1'b1;
            fwd_in   = prod[40:0];
            state_in = ST_SUM_L;
         end
         ST_SUM_L: begin
            dif_in   = prod[40:0];
            wl_in    = round_sat(SUM_W'(fwd_ff) - SUM_W'($signed(prod[40:0])));
            state_in = ST_SUM_R;
         end
         ST_SUM_R: begin
            mul_en   = 1'b1;
            wr_in    = round_sat(SUM_W'(fwd_ff) + SUM_W'(dif_ff));
            state_in = ST_DIV_R;
         end
         ST_DIV_R: begin
            mul_en   = 1'b1;
            ol_in    = other_speed(wl_ff, hold.left_measured, quot);
            state_in = ST_FIN_R;
         end
         ST_FIN_R: begin
            if (load) begin
               out_in.left_main_speed   = wl_ff;
               out_in.left_other_speed  = ol_ff;
               out_in.right_main_speed  = wr_ff;
               out_in.right_other_speed = other_speed(wr_ff, hold.right_measured, quot);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      fwd_ff <= fwd_in;
      dif_ff <= dif_in;
      wl_ff  <= wl_in;
      wr_ff  <= wr_in;
      ol_ff  <= ol_in;
      out_ff <= out_in;
   end

   assign out_valid   = out_valid_ff;
   assign result      = out_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.load = load;

endmodule

[hw/rtl/skid_steer_wheel_speed_sync_top.sv]
// Top level of the skid-steer wheel speed block.
//
//   channel    dir  handshake     carries
//   req_chan   in   valid/ready   command, status sample, current time
//   rsp_chan   out  valid/ready   main and other wheel speeds per side
//   csr_chan   in   valid/ready   register index and write data
//
// An item runs from acceptance to a loaded result, then the block goes idle
// before the next is taken. The shared 25x26 multiplier is used in turn for
// the forward term, the differential term and the two divide-by-five
// quotients. Before the first status sample is kept an item returns to idle
// with no result. Synchronous reset puts control registers at their defaults
// and the state at ST_IDLE. The result register frees the input side; only a
// second finished item waits while the first result is still untaken.
`include "assert_macros.svh"

module skid_steer_wheel_speed_sync_top (
   input  logic       clock,
   input  logic       reset,
   swss_req_if.sink   req_chan,
   swss_rsp_if.source rsp_chan,
   swss_csr_if.sink   csr_chan
);

   swss_pkg::cfg_type        cfg;
   swss_pkg::hold_type       hold;
   swss_pkg::result_type     result;
   swss_pkg::seq_status_type seq_status;
   logic                     req_accept;
   logic                     out_valid;

   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !seq_status.busy;
   assign csr_chan.ready = 1'b1;

   swss_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid && csr_chan.ready),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   swss_hold u_hold (
      .clock               (clock),
      .reset               (reset),
      .accept              (req_accept),
      .new_command         (req_chan.new_command),
      .translation_mm_s    (req_chan.translation_mm_s),
      .rotation_mrad_s     (req_chan.rotation_mrad_s),
      .new_status          (req_chan.new_status),
      .status_time_ms      (req_chan.status_time_ms),
      .left_main_measured  (req_chan.left_main_measured),
      .right_main_measured (req_chan.right_main_measured),
      .now_ms              (req_chan.now_ms),
      .cfg                 (cfg),
      .hold                (hold)
   );

   swss_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .hold      (hold),
      .cfg       (cfg),
      .out_ready (rsp_chan.ready),
      .out_valid (out_valid),
      .result    (result),
      .status    (seq_status)
   );

   assign rsp_chan.valid             = out_valid;
   assign rsp_chan.left_main_speed   = result.left_main_speed;
   assign rsp_chan.left_other_speed  = result.left_other_speed;
   assign rsp_chan.right_main_speed  = result.right_main_speed;
   assign rsp_chan.right_other_speed = result.right_other_speed;

   // an accepted item keeps the input closed while it is worked on
   `SWSS_ASSERT_NEXT(a_accept_closes, clock, reset, req_accept, !req_chan.ready)
   // a result is loaded only into a free or draining output register
   `SWSS_ASSERT_ALWAYS(a_load_free, clock, reset,
      !seq_status.load || !rsp_chan.valid || rsp_chan.ready)
   // a load shows up as a valid result next cycle
   `SWSS_ASSERT_NEXT(a_load_shows, clock, reset, seq_status.load, rsp_chan.valid)

endmodule
